@@ rtl/pidaw_pkg.sv @@
package pidaw_pkg;

	// Word width of every data field and gain register (signed fixed point).
	localparam int DATA_W = 32;

	// Width of the configuration register index.
	localparam int CFG_IDX_W = 3;

	// Input beat: one control step or a clear command.
	typedef struct packed {
		logic                     action;
		logic signed [DATA_W-1:0] error_in;
		logic signed [DATA_W-1:0] ff_term;
	} sample_t;

	// Output beat: clamped drive and the saturation flag.
	typedef struct packed {
		logic signed [DATA_W-1:0] drive;
		logic                     saturated;
	} result_t;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE,
		REG_PROP_GAIN,
		REG_INT_GAIN,
		REG_DERIV_GAIN,
		REG_LIMIT,
		REG_DERIV_ALPHA,
		REG_TRACKING_GAIN
	} cfg_reg_t;

	// Action code that clears the stored state.
	localparam logic ACT_CLEAR = 1'b1;

	// Anti-windup modes.
	localparam logic MODE_CLAMP    = 1'b0;
	localparam logic MODE_BACKCALC = 1'b1;

	// Step sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIFF,
		ST_XERR,
		ST_MLOAD,
		ST_MRUN,
		ST_MRND,
		ST_FILT,
		ST_PROP,
		ST_DERIV,
		ST_FFWD,
		ST_CLAMP,
		ST_INTEG,
		ST_TRACK,
		ST_DONE
	} state_t;

	// Which product the shared serial multiplier is forming.
	typedef enum logic [2:0] {
		MOP_ALPHA,
		MOP_PROP,
		MOP_DERIV,
		MOP_INTEG,
		MOP_TRACK
	} mul_op_t;

endpackage

@@ rtl/pid_antiwindup_controller.sv @@
// PID controller with anti-windup and a low-pass filtered derivative, signed fixed point
// with FRAC_BITS fraction bits.
// Channels: sample (valid/ready) carries one control step or a clear command; result
// (valid/ready) returns exactly one beat per sample; cfg (valid/ready, always ready)
// writes one register per beat and must only be used while the block is idle.
// Each step runs on one shared shift-add multiplier that retires one multiplier bit per
// cycle over DATA_W+3 bits; a product is formed by a load step, one shift step per
// multiplier bit and a rounding step. Mode 0 needs four products, mode 1 five.
// A new sample is accepted only while the sequencer is idle, after the previous step
// has finished. A clear command returns drive 0, saturated 0.
// The result sits in an output register, so the next sample is accepted while the
// previous result still waits; a stalled receiver only holds the sequencer once a new
// result is finished and the output register is still full.
// Reset clears the stored error, integral and filtered derivative, sets the gains and
// mode to zero, the limit to the largest positive value and the filter weight to one.
module pid_antiwindup_controller #(
	parameter int FRAC_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                sample_valid,
	output logic                                sample_ready,
	input  pidaw_pkg::sample_t                  sample,
	output logic                                result_valid,
	input  logic                                result_ready,
	output pidaw_pkg::result_t                  result,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [pidaw_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pidaw_pkg::DATA_W-1:0]        cfg_data
);
	import pidaw_pkg::*;

	localparam int W     = DATA_W;
	localparam int DW    = W + 1;
	localparam int VW    = W + 2;
	localparam int MW    = W + 3;
	localparam int CNT_W = $clog2(MW);
	localparam int RW    = 2 * MW - FRAC_BITS + 1;

	localparam logic [FRAC_BITS:0] ONE_Q   = {1'b1, {FRAC_BITS{1'b0}}};
	localparam logic [W-1:0]       MAG_NEG = {1'b1, {(W-1){1'b0}}};
	localparam logic [W-1:0]       MAG_POS = {1'b0, {(W-1){1'b1}}};

	// Saturate a wide signed sum to the data word.
	function automatic logic [W-1:0] sat_w(input logic [VW-1:0] x);
		logic [W-1:0] r;
		if ((&x[VW-1:W-1]) || !(|x[VW-1:W-1])) begin
			r = x[W-1:0];
		end else if (x[VW-1]) begin
			r = MAG_NEG;
		end else begin
			r = MAG_POS;
		end
		return r;
	endfunction

	// Configuration registers.
	logic                   mode_q;
	logic signed [W-1:0]    kp_q, ki_q, kd_q, kt_q;
	logic [W-2:0]           limit_q;
	logic [FRAC_BITS:0]     alpha_q;

	// Controller state.
	logic signed [W-1:0]    prev_q, integ_q, filt_q;

	// Step working registers.
	state_t                 state_q, state_d;
	mul_op_t                mop_q;
	logic signed [W-1:0]    err_q, ff_q, u_q;
	logic signed [DW-1:0]   diff_q, ia_q;
	logic signed [VW-1:0]   x_q, v_q;
	logic signed [MW-1:0]   e_q;
	logic                   satd_q;

	// Serial multiplier.
	logic [MW-1:0]          mc_q, hi_q, lo_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   neg_q;
	logic [W-1:0]           m_q;

	// Output register.
	result_t                result_q;
	logic                   result_valid_q;

	// Sequencer outputs.
	logic                   accept;
	logic                   res_load;

	logic [FRAC_BITS:0]     alpha_eff;
	logic signed [MW-1:0]   op_a, op_b;
	logic [MW-1:0]          abs_a, abs_b;
	logic [MW:0]            mul_sum;
	logic [2*MW-1:0]        prod;
	logic [RW-1:0]          rnd, lim_r;
	logic [W-1:0]           m_clip;
	logic [W:0]             tx;
	logic [VW-1:0]          acc_base, acc_sum;
	logic [VW-1:0]          lim_v, nlim_v;
	logic                   gt_lim, lt_lim;
	logic [W-1:0]           u_c;
	logic                   err_nn, err_np, v_nn, v_np, same_sign;

	assign cfg_ready    = 1'b1;
	assign result       = result_q;
	assign result_valid = result_valid_q;
	assign accept       = sample_valid && sample_ready;

	// Filter weights above one act as one.
	assign alpha_eff = (alpha_q > ONE_Q) ? ONE_Q : alpha_q;

	// Operand selection for the shared multiplier.
	always_comb begin
		unique case (mop_q)
			MOP_ALPHA: begin
				op_a = MW'(alpha_eff);
				op_b = MW'(x_q);
			end
			MOP_PROP: begin
				op_a = MW'(kp_q);
				op_b = MW'(err_q);
			end
			MOP_DERIV: begin
				op_a = MW'(kd_q);
				op_b = MW'(filt_q);
			end
			MOP_INTEG: begin
				op_a = MW'(ki_q);
				op_b = MW'(err_q);
			end
			MOP_TRACK: begin
				op_a = MW'(kt_q);
				op_b = e_q;
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	assign abs_a = op_a[MW-1] ? MW'(-op_a) : op_a;
	assign abs_b = op_b[MW-1] ? MW'(-op_b) : op_b;

	// One multiplier bit per cycle: add the multiplicand, then shift right.
	assign mul_sum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, mc_q} : '0);

	// Round to nearest with ties away from zero, then clip the magnitude.
	assign prod   = {hi_q, lo_q};
	assign rnd    = RW'(prod[2*MW-1:FRAC_BITS]) + RW'(prod[FRAC_BITS-1]);
	assign lim_r  = neg_q ? RW'(MAG_NEG) : RW'(MAG_POS);
	assign m_clip = (rnd > lim_r) ? lim_r[W-1:0] : rnd[W-1:0];

	// Signed product term: base + (neg ? -m : m) as invert plus carry in.
	assign tx = {1'b0, m_q} ^ {(W+1){neg_q}};

	always_comb begin
		case (state_q)
			ST_FILT:  acc_base = VW'(filt_q);
			ST_DERIV: acc_base = v_q;
			ST_TRACK: acc_base = VW'(ia_q);
			default:  acc_base = VW'(integ_q);
		endcase
	end

	assign acc_sum = acc_base + VW'($signed(tx)) + VW'(neg_q);

	// Output clamp against the symmetric limit.
	assign lim_v  = VW'(limit_q);
	assign nlim_v = VW'(-$signed(lim_v));
	assign gt_lim = $signed(v_q) > $signed(lim_v);
	assign lt_lim = $signed(v_q) < $signed(nlim_v);
	assign u_c    = gt_lim ? lim_v[W-1:0] : (lt_lim ? nlim_v[W-1:0] : v_q[W-1:0]);

	// Same-sign test; zero counts as either sign.
	assign err_nn    = !err_q[W-1];
	assign err_np    = err_q[W-1] || (err_q == '0);
	assign v_nn      = !v_q[VW-1];
	assign v_np      = v_q[VW-1] || (v_q == '0);
	assign same_sign = (err_nn && v_nn) || (err_np && v_np);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (sample_valid) begin
					state_d = (sample.action == ACT_CLEAR) ? ST_DONE : ST_DIFF;
				end
			end
			ST_DIFF:  state_d = ST_XERR;
			ST_XERR:  state_d = ST_MLOAD;
			ST_MLOAD: state_d = ST_MRUN;
			ST_MRUN: begin
				if (cnt_q == '0) begin
					state_d = ST_MRND;
				end
			end
			ST_MRND: begin
				unique case (mop_q)
					MOP_ALPHA: state_d = ST_FILT;
					MOP_PROP:  state_d = ST_PROP;
					MOP_DERIV: state_d = ST_DERIV;
					MOP_INTEG: state_d = ST_INTEG;
					MOP_TRACK: state_d = ST_TRACK;
					default:   state_d = ST_IDLE;
				endcase
			end
			ST_FILT:  state_d = ST_MLOAD;
			ST_PROP:  state_d = ST_MLOAD;
			ST_DERIV: state_d = ST_FFWD;
			ST_FFWD:  state_d = ST_CLAMP;
			ST_CLAMP: state_d = ST_MLOAD;
			ST_INTEG: state_d = (mode_q == MODE_BACKCALC) ? ST_MLOAD : ST_DONE;
			ST_TRACK: state_d = ST_DONE;
			ST_DONE: begin
				if (!result_valid_q || result_ready) begin
					state_d = ST_IDLE;
				end
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		sample_ready = (state_q == ST_IDLE);
		res_load     = (state_q == ST_DONE) && (!result_valid_q || result_ready);
	end

	// Control, configuration and controller state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			mop_q          <= MOP_ALPHA;
			cnt_q          <= '0;
			result_valid_q <= 1'b0;
			mode_q         <= MODE_CLAMP;
			kp_q           <= '0;
			ki_q           <= '0;
			kd_q           <= '0;
			kt_q           <= '0;
			limit_q        <= '1;
			alpha_q        <= ONE_Q;
			prev_q         <= '0;
			integ_q        <= '0;
			filt_q         <= '0;
		end else begin
			state_q <= state_d;

			// Output register holds a beat until the receiver takes it.
			if (res_load) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end

			// Register writes.
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_MODE:          mode_q  <= cfg_data[0];
					REG_PROP_GAIN:     kp_q    <= cfg_data;
					REG_INT_GAIN:      ki_q    <= cfg_data;
					REG_DERIV_GAIN:    kd_q    <= cfg_data;
					REG_LIMIT:         limit_q <= cfg_data[W-2:0];
					REG_DERIV_ALPHA:   alpha_q <= cfg_data[FRAC_BITS:0];
					REG_TRACKING_GAIN: kt_q    <= cfg_data;
					default: ;
				endcase
			end

			// Product selection and bit counter.
			case (state_q)
				ST_XERR:  mop_q <= MOP_ALPHA;
				ST_FILT:  mop_q <= MOP_PROP;
				ST_PROP:  mop_q <= MOP_DERIV;
				ST_CLAMP: mop_q <= MOP_INTEG;
				ST_INTEG: mop_q <= MOP_TRACK;
				default: ;
			endcase
			if (state_q == ST_MLOAD) begin
				cnt_q <= CNT_W'(MW - 1);
			end else if (state_q == ST_MRUN) begin
				cnt_q <= cnt_q - 1'b1;
			end

			// Stored state updates.
			if (accept && sample.action == ACT_CLEAR) begin
				prev_q  <= '0;
				integ_q <= '0;
				filt_q  <= '0;
			end
			if (state_q == ST_FILT) begin
				filt_q <= sat_w(acc_sum);
				prev_q <= err_q;
			end
			if (state_q == ST_INTEG && mode_q == MODE_CLAMP && !(satd_q && same_sign)) begin
				integ_q <= sat_w(acc_sum);
			end
			if (state_q == ST_TRACK) begin
				integ_q <= sat_w(acc_sum);
			end
		end
	end

	// Step datapath and output payload.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				err_q  <= sample.error_in;
				ff_q   <= sample.ff_term;
				u_q    <= '0;
				satd_q <= 1'b0;
			end
			ST_DIFF:  diff_q <= DW'(err_q) - DW'(prev_q);
			ST_XERR:  x_q    <= VW'(diff_q) - VW'(filt_q);
			ST_MLOAD: begin
				mc_q  <= abs_a;
				lo_q  <= abs_b;
				hi_q  <= '0;
				neg_q <= op_a[MW-1] ^ op_b[MW-1];
			end
			ST_MRUN: begin
				hi_q <= mul_sum[MW:1];
				lo_q <= {mul_sum[0], lo_q[MW-1:1]};
			end
			ST_MRND:  m_q <= m_clip;
			ST_PROP:  v_q <= acc_sum;
			ST_DERIV: v_q <= acc_sum;
			ST_FFWD: begin
				if (mode_q == MODE_CLAMP) begin
					v_q <= v_q + VW'(ff_q);
				end
			end
			ST_CLAMP: begin
				u_q    <= u_c;
				satd_q <= gt_lim || lt_lim;
			end
			ST_INTEG: begin
				ia_q <= acc_sum[DW-1:0];
				e_q  <= MW'(u_q) - MW'(v_q);
			end
			default: ;
		endcase

		if (res_load) begin
			result_q.drive     <= u_q;
			result_q.saturated <= satd_q;
		end
	end

	// The delivered drive never leaves the clamp range.
	a_drive_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> ($signed(result.drive) <= $signed({1'b0, limit_q}) &&
			$signed(result.drive) >= -$signed({1'b0, limit_q})))
		else $error("drive outside the clamp range");

	// A saturated beat sits exactly on one of the clamp bounds.
	a_sat_on_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.saturated) |->
			($signed(result.drive) == $signed({1'b0, limit_q}) ||
			$signed(result.drive) == -$signed({1'b0, limit_q})))
		else $error("saturated beat not on a clamp bound");

	// A rounded product magnitude never exceeds the signed word range.
	a_prod_clipped: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MRND) |=> (m_q <= MAG_NEG))
		else $error("product magnitude not clipped");

endmodule
